// ===== rtl/core/double_ended_queue_macros.svh =====
// Assertion macros for the double-ended queue checker.
// Needs clock and reset in the scope that uses them.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, disabled in reset
`define DQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/dq_pkg.sv =====
// Shared constants, operation and status codes, and step struct for the
// double-ended queue. No dependencies.
package dq_pkg;

   // ring depth, power of two (pointers wrap by truncation)
   localparam int DEPTH        = 64;
   localparam int ADDR_WIDTH   = $clog2(DEPTH);
   localparam int COUNT_WIDTH  = ADDR_WIDTH + 1;
   localparam int DATA_WIDTH   = 32;
   localparam int FUNC_WIDTH   = 3;
   localparam int KEEP_WIDTH   = 7;
   localparam int STATUS_WIDTH = 2;

   localparam logic [FUNC_WIDTH-1:0] FN_PUSH_BACK  = 3'd0;
   localparam logic [FUNC_WIDTH-1:0] FN_PUSH_FRONT = 3'd1;
   localparam logic [FUNC_WIDTH-1:0] FN_POP_BACK   = 3'd2;
   localparam logic [FUNC_WIDTH-1:0] FN_POP_FRONT  = 3'd3;
   localparam logic [FUNC_WIDTH-1:0] FN_TRIM_FRONT = 3'd4;
   localparam logic [FUNC_WIDTH-1:0] FN_TRIM_BACK  = 3'd5;

   localparam logic [STATUS_WIDTH-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd2;

   // word layouts
   localparam int REQ_DATA_WIDTH = 40;
   localparam int RSP_DATA_WIDTH = 80;
   localparam int RSP_COUNT_LSB  = 0;
   localparam int RSP_EMPTY_BIT  = RSP_COUNT_LSB + COUNT_WIDTH;
   localparam int RSP_FRONT_LSB  = RSP_EMPTY_BIT + 1;
   localparam int RSP_BACK_LSB   = RSP_FRONT_LSB + DATA_WIDTH;
   localparam int RSP_STATUS_LSB = RSP_BACK_LSB + DATA_WIDTH;
   localparam int RSP_USED_BITS  = RSP_STATUS_LSB + STATUS_WIDTH;

   typedef struct packed {
      logic                    wr_en;
      logic [ADDR_WIDTH-1:0]   wr_addr;
      logic [ADDR_WIDTH-1:0]   front_addr;
      logic [ADDR_WIDTH-1:0]   back_addr;
      logic [COUNT_WIDTH-1:0]  count;
      logic [STATUS_WIDTH-1:0] status;
   } dq_step_type;

endpackage

// ===== rtl/core/dq_ctrl.sv =====
// Head pointer and count registers with the per-operation next-state logic.
// Depends on dq_pkg.
module dq_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [dq_pkg::FUNC_WIDTH-1:0]    func,
   input  logic [dq_pkg::KEEP_WIDTH-1:0]    keep_count,
   output dq_pkg::dq_step_type              step
);

   logic [dq_pkg::ADDR_WIDTH-1:0]   head_ff, head_in;
   logic [dq_pkg::COUNT_WIDTH-1:0]  count_ff, count_in;
   logic                            full, empty;
   logic                            wr_en;
   logic [dq_pkg::ADDR_WIDTH-1:0]   wr_addr;
   logic [dq_pkg::STATUS_WIDTH-1:0] status;

   assign full  = (count_ff == dq_pkg::COUNT_WIDTH'(dq_pkg::DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = head_ff + count_ff[dq_pkg::ADDR_WIDTH-1:0];
      status   = dq_pkg::ST_DONE;
      unique case (func)
         dq_pkg::FN_PUSH_BACK: begin
            if (full) begin
               status = dq_pkg::ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + dq_pkg::COUNT_WIDTH'(1);
            end
         end
         dq_pkg::FN_PUSH_FRONT: begin
            if (full) begin
               status = dq_pkg::ST_FULL;
            end else begin
               head_in  = head_ff - dq_pkg::ADDR_WIDTH'(1);
               wr_en    = 1'b1;
               wr_addr  = head_ff - dq_pkg::ADDR_WIDTH'(1);
               count_in = count_ff + dq_pkg::COUNT_WIDTH'(1);
            end
         end
         dq_pkg::FN_POP_BACK: begin
            if (empty) begin
               status = dq_pkg::ST_EMPTY;
            end else begin
               count_in = count_ff - dq_pkg::COUNT_WIDTH'(1);
            end
         end
         dq_pkg::FN_POP_FRONT: begin
            if (empty) begin
               status = dq_pkg::ST_EMPTY;
            end else begin
               head_in  = head_ff + dq_pkg::ADDR_WIDTH'(1);
               count_in = count_ff - dq_pkg::COUNT_WIDTH'(1);
            end
         end
         dq_pkg::FN_TRIM_FRONT: begin
            if (count_ff > keep_count) begin
               head_in  = head_ff + dq_pkg::ADDR_WIDTH'(count_ff - keep_count);
               count_in = keep_count;
            end
         end
         dq_pkg::FN_TRIM_BACK: begin
            if (count_ff > keep_count) begin
               count_in = keep_count;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (advance) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   assign step.wr_en      = wr_en;
   assign step.wr_addr    = wr_addr;
   assign step.front_addr = head_in;
   assign step.back_addr  = head_in
                          + dq_pkg::ADDR_WIDTH'(count_in - dq_pkg::COUNT_WIDTH'(1));
   assign step.count      = count_in;
   assign step.status     = status;

endmodule

// ===== rtl/core/dq_ram.sv =====
// Entry store: one write port, two registered read ports (old data on collision).
// Depends on dq_pkg.
module dq_ram (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [dq_pkg::ADDR_WIDTH-1:0]  wr_addr,
   input  logic [dq_pkg::DATA_WIDTH-1:0]  wr_data,
   input  logic                           rd_en,
   input  logic [dq_pkg::ADDR_WIDTH-1:0]  rd_addr_a,
   input  logic [dq_pkg::ADDR_WIDTH-1:0]  rd_addr_b,
   output logic [dq_pkg::DATA_WIDTH-1:0]  rd_data_a,
   output logic [dq_pkg::DATA_WIDTH-1:0]  rd_data_b
);

   logic [dq_pkg::DATA_WIDTH-1:0] mem [dq_pkg::DEPTH];
   logic [dq_pkg::DATA_WIDTH-1:0] rd_a_ff, rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/core/dq_rsp.sv =====
// Result register: count, status, write-bypass flags and output word assembly.
// Depends on dq_pkg.
module dq_rsp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  dq_pkg::dq_step_type                 step,
   input  logic [dq_pkg::DATA_WIDTH-1:0]       push_value,
   input  logic [dq_pkg::DATA_WIDTH-1:0]       rd_front,
   input  logic [dq_pkg::DATA_WIDTH-1:0]       rd_back,
   output logic                                ready,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dq_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata
);

   logic                             valid_ff, valid_in;
   logic [dq_pkg::COUNT_WIDTH-1:0]   count_ff;
   logic [dq_pkg::STATUS_WIDTH-1:0]  status_ff;
   logic                             byp_front_ff, byp_back_ff;
   logic [dq_pkg::DATA_WIDTH-1:0]    push_ff;
   logic                             is_empty;
   logic [dq_pkg::DATA_WIDTH-1:0]    front_value, back_value;

   assign ready    = !valid_ff || rsp_tready;
   assign valid_in = advance || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         count_ff     <= step.count;
         status_ff    <= step.status;
         byp_front_ff <= step.wr_en && (step.wr_addr == step.front_addr);
         byp_back_ff  <= step.wr_en && (step.wr_addr == step.back_addr);
         push_ff      <= push_value;
      end
   end

   // same-cycle write lands after the read, so take the pushed word directly
   assign is_empty    = (count_ff == '0);
   assign front_value = is_empty ? '0 : (byp_front_ff ? push_ff : rd_front);
   assign back_value  = is_empty ? '0 : (byp_back_ff ? push_ff : rd_back);

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {(dq_pkg::RSP_DATA_WIDTH - dq_pkg::RSP_USED_BITS)'(0),
                        status_ff, back_value, front_value, is_empty, count_ff};

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// Bounded double-ended queue, top level.
// Depends on dq_pkg, dq_ctrl, dq_ram and dq_rsp.
//
// Request channel (req_): one word per operation; req_tuser carries the
// operation (push back, push front, pop back, pop front, trim front, trim
// back), req_tdata the pushed value and the kept count for trims.
// Response channel (rsp_): exactly one word per request, in order, with
// the count, the empty flag, front and back values (zero when empty) and
// a status: done, push refused because full, or pop refused because empty.
// Latency: the response is valid in the cycle after the request is taken.
// Throughput: one operation per cycle while responses are taken; the head/count
// update, the store write and the two registered reads of the new front and
// back all happen at the same clock edge.
// Stall: while a response waits on rsp_tready it holds steady and
// req_tready drops, so nothing is lost; it rises again as the word leaves.
// Reset empties the queue (head and count cleared, no response pending);
// the store itself is not cleared, unwritten slots are never shown.
module double_ended_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] push_value, [38:32] keep_count, [39] zero
   input  logic [dq_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // [2:0] func
   input  logic [dq_pkg::FUNC_WIDTH-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [6:0] entry_count, [7] is_empty, [39:8] front_value, [71:40] back_value,
   // [73:72] status, [79:74] zero
   output logic [dq_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata
);

   logic                            ready;
   logic                            advance;
   logic [dq_pkg::DATA_WIDTH-1:0]   push_value;
   logic [dq_pkg::KEEP_WIDTH-1:0]   keep_count;
   dq_pkg::dq_step_type             step;
   logic [dq_pkg::DATA_WIDTH-1:0]   rd_front, rd_back;

   assign push_value = req_tdata[dq_pkg::DATA_WIDTH-1:0];
   assign keep_count = req_tdata[dq_pkg::DATA_WIDTH +: dq_pkg::KEEP_WIDTH];
   assign req_tready = ready;
   assign advance    = req_tvalid && ready;

   dq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .func       (req_tuser),
      .keep_count (keep_count),
      .step       (step)
   );

   dq_ram u_ram (
      .clock     (clock),
      .wr_en     (advance && step.wr_en),
      .wr_addr   (step.wr_addr),
      .wr_data   (push_value),
      .rd_en     (advance),
      .rd_addr_a (step.front_addr),
      .rd_addr_b (step.back_addr),
      .rd_data_a (rd_front),
      .rd_data_b (rd_back)
   );

   dq_rsp u_rsp (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .step       (step),
      .push_value (push_value),
      .rd_front   (rd_front),
      .rd_back    (rd_back),
      .ready      (ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/core/dq_checker.sv =====
// Port-level checks on the double-ended queue response channel, and the bind.
// Depends on dq_pkg and double_ended_queue_macros.svh.
`include "double_ended_queue_macros.svh"

module dq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [dq_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata
);

   logic [dq_pkg::COUNT_WIDTH-1:0]  rsp_count;
   logic                            rsp_is_empty;
   logic [dq_pkg::DATA_WIDTH-1:0]   rsp_front, rsp_back;
   logic [dq_pkg::STATUS_WIDTH-1:0] rsp_status;

   assign rsp_count    = rsp_tdata[dq_pkg::RSP_COUNT_LSB +: dq_pkg::COUNT_WIDTH];
   assign rsp_is_empty = rsp_tdata[dq_pkg::RSP_EMPTY_BIT];
   assign rsp_front    = rsp_tdata[dq_pkg::RSP_FRONT_LSB +: dq_pkg::DATA_WIDTH];
   assign rsp_back     = rsp_tdata[dq_pkg::RSP_BACK_LSB +: dq_pkg::DATA_WIDTH];
   assign rsp_status   = rsp_tdata[dq_pkg::RSP_STATUS_LSB +: dq_pkg::STATUS_WIDTH];

   `DQ_ASSERT_NOW(a_empty_flag, rsp_tvalid, rsp_is_empty == (rsp_count == '0), "empty flag disagrees with count")
   `DQ_ASSERT_NOW(a_empty_zero, rsp_tvalid && rsp_is_empty, (rsp_front == '0) && (rsp_back == '0), "empty queue shows data")
   `DQ_ASSERT_NOW(a_full_status, rsp_tvalid && (rsp_status == dq_pkg::ST_FULL), rsp_count == dq_pkg::COUNT_WIDTH'(dq_pkg::DEPTH), "push refused while not full")
   `DQ_ASSERT_NOW(a_empty_status, rsp_tvalid && (rsp_status == dq_pkg::ST_EMPTY), rsp_count == '0, "pop refused while not empty")
   `DQ_ASSERT_NEXT(a_stall_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response word changed")

endmodule

bind double_ended_queue dq_checker u_dq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/double_ended_queue_tb.sv =====
// Self-checking bench for double_ended_queue: directed corner words, a forced
// fill under a long response stall, then random fill/drain/mixed phases.
// Depends on dq_pkg and the double_ended_queue RTL only.
`timescale 1ns / 100ps

module double_ended_queue_tb;

   localparam int ITEMS       = 1150;
   localparam int HOLD_CYCLES = 250;
   localparam int LIMIT       = 2000;
   localparam int SHOW_MAX    = 40;

   // unused operation codes, no-ops
   localparam logic [dq_pkg::FUNC_WIDTH-1:0] FN_NOP_LO = 3'd6;
   localparam logic [dq_pkg::FUNC_WIDTH-1:0] FN_NOP_HI = 3'd7;

   typedef struct packed {
      logic [dq_pkg::COUNT_WIDTH-1:0]  count;
      logic                            empty;
      logic [dq_pkg::DATA_WIDTH-1:0]   front;
      logic [dq_pkg::DATA_WIDTH-1:0]   back;
      logic [dq_pkg::STATUS_WIDTH-1:0] status;
   } deque_view_type;

   class deque_shadow_type;
      bit [dq_pkg::DATA_WIDTH-1:0]  slots [dq_pkg::DEPTH];
      bit [dq_pkg::ADDR_WIDTH-1:0]  head;
      bit [dq_pkg::COUNT_WIDTH-1:0] held;
      deque_view_type               due_views [$];
      int checked, refused_full, refused_empty, mismatches;

      function int pending();
         return due_views.size();
      endfunction

      function void note_op(logic [dq_pkg::FUNC_WIDTH-1:0] fn,
                            logic [dq_pkg::DATA_WIDTH-1:0] value,
                            logic [dq_pkg::KEEP_WIDTH-1:0] keep);
         deque_view_type v;
         bit [dq_pkg::ADDR_WIDTH-1:0] slot;
         v.status = dq_pkg::ST_DONE;
         case (fn)
            dq_pkg::FN_PUSH_BACK: begin
               if (held == dq_pkg::DEPTH) begin
                  v.status = dq_pkg::ST_FULL;
               end else begin
                  slot = head + held[dq_pkg::ADDR_WIDTH-1:0];
                  slots[slot] = value;
                  held++;
               end
            end
            dq_pkg::FN_PUSH_FRONT: begin
               if (held == dq_pkg::DEPTH) begin
                  v.status = dq_pkg::ST_FULL;
               end else begin
                  head = head - 1'b1;
                  slots[head] = value;
                  held++;
               end
            end
            dq_pkg::FN_POP_BACK: begin
               if (held == 0) v.status = dq_pkg::ST_EMPTY;
               else held--;
            end
            dq_pkg::FN_POP_FRONT: begin
               if (held == 0) begin
                  v.status = dq_pkg::ST_EMPTY;
               end else begin
                  head = head + 1'b1;
                  held--;
               end
            end
            dq_pkg::FN_TRIM_FRONT: begin
               if (held > keep) begin
                  slot = dq_pkg::ADDR_WIDTH'(held - keep);
                  head = head + slot;
                  held = keep;
               end
            end
            dq_pkg::FN_TRIM_BACK: begin
               if (held > keep) held = keep;
            end
            default: ;
         endcase
         v.count = held;
         v.empty = (held == 0);
         if (held == 0) begin
            v.front = '0;
            v.back  = '0;
         end else begin
            slot    = head + held[dq_pkg::ADDR_WIDTH-1:0] - 1'b1;
            v.front = slots[head];
            v.back  = slots[slot];
         end
         if (v.status == dq_pkg::ST_FULL) refused_full++;
         if (v.status == dq_pkg::ST_EMPTY) refused_empty++;
         due_views = {due_views, v};
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         mismatches++;
         if (mismatches <= SHOW_MAX)
            $display("%0t: response %0d, %s: got %h, expected %h",
                     $time, checked, what, got, want);
      endtask

      task check_view(logic [dq_pkg::RSP_DATA_WIDTH-1:0] word);
         deque_view_type                  want;
         logic [dq_pkg::COUNT_WIDTH-1:0]  got_count;
         logic [dq_pkg::DATA_WIDTH-1:0]   got_front, got_back;
         logic [dq_pkg::STATUS_WIDTH-1:0] got_status;
         if (due_views.size() == 0) begin
            report("word with nothing outstanding", word[31:0], 0);
            return;
         end
         want = due_views[0];
         due_views.delete(0);
         checked++;
         got_count  = word[dq_pkg::RSP_COUNT_LSB +: dq_pkg::COUNT_WIDTH];
         got_front  = word[dq_pkg::RSP_FRONT_LSB +: dq_pkg::DATA_WIDTH];
         got_back   = word[dq_pkg::RSP_BACK_LSB +: dq_pkg::DATA_WIDTH];
         got_status = word[dq_pkg::RSP_STATUS_LSB +: dq_pkg::STATUS_WIDTH];
         if (got_count !== want.count)
            report("entry_count", got_count, want.count);
         if (word[dq_pkg::RSP_EMPTY_BIT] !== want.empty)
            report("is_empty", word[dq_pkg::RSP_EMPTY_BIT], want.empty);
         if (got_front !== want.front)
            report("front_value", got_front, want.front);
         if (got_back !== want.back)
            report("back_value", got_back, want.back);
         if (got_status !== want.status)
            report("status", got_status, want.status);
         if (word[dq_pkg::RSP_DATA_WIDTH-1:dq_pkg::RSP_USED_BITS] !== '0)
            report("padding", word[dq_pkg::RSP_DATA_WIDTH-1:dq_pkg::RSP_USED_BITS], 0);
      endtask

      task close();
         if (due_views.size() != 0)
            report("words never delivered", due_views.size(), 0);
      endtask
   endclass

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [dq_pkg::REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   logic [dq_pkg::FUNC_WIDTH-1:0]     req_tuser  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [dq_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;

   deque_shadow_type tracker = new();
   bit steady    = 1'b0;
   bit long_hold = 1'b0;
   bit holding   = 1'b0;
   int sent      = 0;
   int quiet     = 0;

   double_ended_queue uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [dq_pkg::FUNC_WIDTH-1:0] pick_func(int push_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < push_pct)
         return $urandom_range(0, 1) ? dq_pkg::FN_PUSH_FRONT : dq_pkg::FN_PUSH_BACK;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(0, 1) ? dq_pkg::FN_POP_FRONT : dq_pkg::FN_POP_BACK;
      if (r < 96)
         return $urandom_range(0, 1) ? dq_pkg::FN_TRIM_FRONT : dq_pkg::FN_TRIM_BACK;
      return $urandom_range(0, 1) ? FN_NOP_HI : FN_NOP_LO;
   endfunction

   function automatic logic [dq_pkg::KEEP_WIDTH-1:0] pick_keep();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return dq_pkg::KEEP_WIDTH'($urandom_range(0, dq_pkg::DEPTH));
      if (r < 90) return dq_pkg::KEEP_WIDTH'($urandom_range(0, 8));
      return dq_pkg::KEEP_WIDTH'($urandom_range(dq_pkg::DEPTH + 1, 127));
   endfunction

   function automatic logic [dq_pkg::DATA_WIDTH-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return '0;
      if (r < 8) return '1;
      return $urandom;
   endfunction

   task automatic issue_op(logic [dq_pkg::FUNC_WIDTH-1:0] fn,
                           logic [dq_pkg::DATA_WIDTH-1:0] value,
                           logic [dq_pkg::KEEP_WIDTH-1:0] keep);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= fn;
      req_tdata  <= {1'b0, keep, value};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic await_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // check the response before noting the request taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.check_view(rsp_tdata);
         if (req_tvalid && req_tready)
            tracker.note_op(req_tuser, req_tdata[dq_pkg::DATA_WIDTH-1:0],
                            req_tdata[dq_pkg::DATA_WIDTH +: dq_pkg::KEEP_WIDTH]);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet = 0;
      end else begin
         quiet = quiet + 1;
         if (quiet >= LIMIT) begin
            $display("timeout: no word moved for %0d cycles", LIMIT);
            $display("double_ended_queue_tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      int gap;
      wait (!reset);
      forever begin
         if (long_hold) begin
            holding = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holding   = 1'b0;
            long_hold = 1'b0;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   initial begin
      int len, push_pct;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty-queue refusals, trims on empty, unused codes, then corner-value pushes with trims and pops
      issue_op(dq_pkg::FN_POP_BACK, $urandom, 7'd0);
      issue_op(dq_pkg::FN_POP_FRONT, $urandom, 7'd0);
      issue_op(dq_pkg::FN_TRIM_FRONT, $urandom, 7'd0);
      issue_op(dq_pkg::FN_TRIM_BACK, $urandom, 7'd0);
      issue_op(FN_NOP_LO, $urandom, 7'd127);
      issue_op(FN_NOP_HI, $urandom, 7'd0);
      issue_op(dq_pkg::FN_PUSH_BACK, 32'hFFFF_FFFF, 7'd0);
      issue_op(dq_pkg::FN_PUSH_FRONT, 32'h0000_0000, 7'd0);
      issue_op(dq_pkg::FN_PUSH_BACK, 32'hA5A5_A5A5, 7'd0);
      issue_op(dq_pkg::FN_PUSH_FRONT, 32'h5A5A_5A5A, 7'd0);
      issue_op(dq_pkg::FN_PUSH_BACK, 32'h0000_0001, 7'd0);
      issue_op(dq_pkg::FN_TRIM_FRONT, $urandom, 7'd127);
      issue_op(dq_pkg::FN_TRIM_BACK, $urandom, 7'd64);
      issue_op(dq_pkg::FN_TRIM_FRONT, $urandom, 7'd4);
      issue_op(dq_pkg::FN_TRIM_BACK, $urandom, 7'd3);
      issue_op(dq_pkg::FN_POP_FRONT, $urandom, 7'd0);
      issue_op(dq_pkg::FN_POP_BACK, $urandom, 7'd0);
      issue_op(dq_pkg::FN_POP_BACK, $urandom, 7'd0);
      issue_op(dq_pkg::FN_POP_FRONT, $urandom, 7'd0);
      issue_op(dq_pkg::FN_PUSH_FRONT, 32'h8000_0000, 7'd0);
      issue_op(dq_pkg::FN_PUSH_BACK, 32'h7FFF_FFFF, 7'd0);
      issue_op(dq_pkg::FN_PUSH_FRONT, 32'h1234_5678, 7'd0);
      issue_op(dq_pkg::FN_TRIM_FRONT, $urandom, 7'd0);
      issue_op(dq_pkg::FN_PUSH_BACK, 32'hDEAD_BEEF, 7'd0);
      issue_op(dq_pkg::FN_TRIM_BACK, $urandom, 7'd0);
      await_drain();

      // fill past full while responses are held back
      long_hold = 1'b1;
      steady    = 1'b1;
      while (!holding) @(posedge clock);
      repeat (dq_pkg::DEPTH + 6)
         issue_op($urandom_range(0, 1) ? dq_pkg::FN_PUSH_FRONT : dq_pkg::FN_PUSH_BACK,
                  pick_value(), 7'd0);
      issue_op(dq_pkg::FN_TRIM_FRONT, $urandom, 7'd64);
      steady = 1'b0;
      await_drain();

      while (sent < ITEMS) begin
         case ($urandom_range(0, 3))
            0: push_pct = 85;
            1: push_pct = 15;
            default: push_pct = 50;
         endcase
         steady = ($urandom_range(0, 3) == 0);
         len = $urandom_range(40, 140);
         repeat (len)
            if (sent < ITEMS) issue_op(pick_func(push_pct), pick_value(), pick_keep());
         if ($urandom_range(0, 2) == 0) await_drain();
      end
      steady = 1'b0;
      await_drain();
      repeat (4) @(posedge clock);
      tracker.close();

      $display("run covered %0d operations and %0d checked responses,",
               sent, tracker.checked);
      $display("with %0d pushes refused on a full queue and %0d pops refused on an empty one",
               tracker.refused_full, tracker.refused_empty);
      if (tracker.mismatches == 0)
         $display("double_ended_queue_tb: PASS");
      else
         $display("double_ended_queue_tb: FAIL");
      $finish;
   end

endmodule
